// File: design/btb_pkg.sv
// shared types and constants for the branch target buffer tracker
`timescale 1ns / 1ps
`default_nettype none
package btb_pkg;

  localparam int ADDR_W     = 64;
  localparam int QIDX_W     = 10;
  localparam int OUT_IDX_W  = 10;
  localparam int TOTAL_W    = 32;

  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef struct packed {
    logic                 cmd;
    logic [ADDR_W-1:0]    branch_addr;
    logic [QIDX_W-1:0]    query_index;
  } btb_in_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] entry_index;
    logic                 was_hit;
    logic                 was_allocated;
    logic [TOTAL_W-1:0]   alloc_total;
    logic [TOTAL_W-1:0]   hit_total;
  } btb_out_t;

  typedef struct packed {
    logic write_en;
    logic was_hit;
    logic was_allocated;
  } btb_flags_t;

endpackage
`default_nettype wire

// File: design/btb_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module btb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: design/btb_update.sv
// entry update: tag compare, saturating counters and new entry word
`timescale 1ns / 1ps
`default_nettype none
module btb_update
  import btb_pkg::*;
#(
  parameter int TAG_W      = 53,
  parameter int COUNT_BITS = 32
) (
  input  wire logic                               cmd,
  input  wire logic [TAG_W-1:0]                   tag,
  input  wire logic [1+TAG_W+2*COUNT_BITS-1:0]    entry,
  output      logic [1+TAG_W+2*COUNT_BITS-1:0]    entry_nxt,
  output      logic [COUNT_BITS-1:0]              alloc_cnt,
  output      logic [COUNT_BITS-1:0]              hit_cnt,
  output      btb_flags_t                         flags
);

  logic                  old_valid;
  logic [TAG_W-1:0]      old_tag;
  logic [COUNT_BITS-1:0] old_alloc;
  logic [COUNT_BITS-1:0] old_hit;
  logic                  match;
  logic                  is_access;
  logic                  new_valid;
  logic [TAG_W-1:0]      new_tag;

  assign {old_valid, old_tag, old_alloc, old_hit} = entry;
  assign is_access = (cmd == CMD_ACCESS);
  assign match     = old_valid && (old_tag == tag);

  always_comb begin
    flags.write_en      = is_access;
    flags.was_hit       = is_access && match;
    flags.was_allocated = is_access && !match;
    new_valid = old_valid;
    new_tag   = old_tag;
    alloc_cnt = old_alloc;
    hit_cnt   = old_hit;
    if (flags.was_hit && (old_hit != '1)) begin
      hit_cnt = old_hit + COUNT_BITS'(1);
    end
    if (flags.was_allocated) begin
      new_valid = 1'b1;
      new_tag   = tag;
      if (old_alloc != '1) begin
        alloc_cnt = old_alloc + COUNT_BITS'(1);
      end
    end
  end

  assign entry_nxt = {new_valid, new_tag, alloc_cnt, hit_cnt};

endmodule
`default_nettype wire

// File: design/direct_mapped_btb_tracker.sv
// top level of the direct-mapped branch target buffer occupancy tracker
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Input beats: drive in_data and raise start; a beat is taken at a rising
//   edge where start is high and busy is low. cmd selects an access (branch
//   address looked up, tag filled or hit counted) or a query (counters of
//   query_index reported, nothing changed).
//   Results: every beat gives exactly one result on out_data, marked by
//   out_valid for one cycle, after the stage-1 and output registers. The
//   receiver cannot stall; results must be taken when shown.
//   Throughput: one beat per cycle while busy is low. Each beat does one
//   read of the entry memory; an access beat also writes the entry back in
//   the next cycle. A beat that follows a write to the same entry takes the
//   written word from a forwarding register instead of the memory.
//   Reset: after rst_n is released a clearing pass writes every entry of
//   the memory to zero, one entry per cycle. busy stays high for that pass
//   and is low from then on.
module direct_mapped_btb_tracker
  import btb_pkg::*;
#(
  parameter int TABLE_ENTRIES = 1024,
  parameter int COUNT_BITS    = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output      logic     busy,
  input  wire btb_in_t  in_data,
  output      logic     out_valid,
  output      btb_out_t out_data
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int VA_W   = ADDR_W - 1;
  localparam bit POW2   = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
  localparam int TAG_W  = POW2 ? (VA_W - IDX_W) : VA_W;
  localparam int MEM_W  = 1 + TAG_W + 2 * COUNT_BITS;
  localparam int IEXT_W = (IDX_W > QIDX_W) ? IDX_W : QIDX_W;
  localparam int CEXT_W = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;
  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

  logic                  accept;
  logic [VA_W-1:0]       va;
  logic [VA_W-1:0]       tag_full;
  logic [TAG_W-1:0]      tag_in;
  logic [IEXT_W-1:0]     qidx_ext;
  logic [IDX_W-1:0]      idx_in;

  logic                  clr_active_r, clr_active_nxt;
  logic [IDX_W-1:0]      clr_idx_r, clr_idx_nxt;

  logic                  s1_vld_r, s1_vld_nxt;
  logic                  s1_cmd_r;
  logic [IDX_W-1:0]      s1_idx_r;
  logic [TAG_W-1:0]      s1_tag_r;
  logic                  fwd_sel_r, fwd_sel_nxt;
  logic [MEM_W-1:0]      fwd_data_r;

  logic [MEM_W-1:0]      rd_data;
  logic [MEM_W-1:0]      cur_entry;
  logic [MEM_W-1:0]      upd_entry;
  logic [COUNT_BITS-1:0] upd_alloc;
  logic [COUNT_BITS-1:0] upd_hit;
  btb_flags_t            upd_flags;
  logic                  s1_wr;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [MEM_W-1:0]      mem_wdata;

  logic                  out_valid_r, out_valid_nxt;
  btb_out_t              out_r, out_nxt;
  logic [IEXT_W-1:0]     oidx_ext;
  logic [CEXT_W-1:0]     alloc_ext;
  logic [CEXT_W-1:0]     hit_ext;

  // index and tag of the incoming beat
  assign busy     = clr_active_r;
  assign accept   = start && !clr_active_r;
  assign va       = in_data.branch_addr[ADDR_W-1:1];
  assign tag_full = va & ~VA_W'(IDX_MASK);
  assign tag_in   = tag_full[VA_W-1 -: TAG_W];
  assign qidx_ext = IEXT_W'(in_data.query_index);
  assign idx_in   = (in_data.cmd == CMD_ACCESS) ? (va[IDX_W-1:0] & IDX_MASK)
                                                : (qidx_ext[IDX_W-1:0] & IDX_MASK);

  btb_ram #(
    .WIDTH (MEM_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (accept),
    .rd_addr (idx_in),
    .rd_data (rd_data)
  );

  assign cur_entry = fwd_sel_r ? fwd_data_r : rd_data;

  btb_update #(
    .TAG_W      (TAG_W),
    .COUNT_BITS (COUNT_BITS)
  ) u_update (
    .cmd       (s1_cmd_r),
    .tag       (s1_tag_r),
    .entry     (cur_entry),
    .entry_nxt (upd_entry),
    .alloc_cnt (upd_alloc),
    .hit_cnt   (upd_hit),
    .flags     (upd_flags)
  );

  assign s1_wr = s1_vld_r && upd_flags.write_en;

  always_comb begin
    if (clr_active_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_r;
      mem_wdata = '0;
    end else begin
      mem_we    = s1_wr;
      mem_waddr = s1_idx_r;
      mem_wdata = upd_entry;
    end
  end

  // clearing pass and pipeline control
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_idx_nxt    = clr_idx_r;
    if (clr_active_r) begin
      clr_idx_nxt = clr_idx_r + IDX_W'(1);
      if (clr_idx_r == IDX_LAST) begin
        clr_active_nxt = 1'b0;
      end
    end
    s1_vld_nxt    = accept;
    fwd_sel_nxt   = accept && s1_wr && (idx_in == s1_idx_r);
    out_valid_nxt = s1_vld_r;
  end

  assign oidx_ext  = IEXT_W'(s1_idx_r);
  assign alloc_ext = CEXT_W'(upd_alloc);
  assign hit_ext   = CEXT_W'(upd_hit);

  always_comb begin
    out_nxt.entry_index   = oidx_ext[OUT_IDX_W-1:0];
    out_nxt.was_hit       = upd_flags.was_hit;
    out_nxt.was_allocated = upd_flags.was_allocated;
    out_nxt.alloc_total   = alloc_ext[TOTAL_W-1:0];
    out_nxt.hit_total     = hit_ext[TOTAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
      s1_vld_r     <= 1'b0;
      fwd_sel_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_idx_r    <= clr_idx_nxt;
      s1_vld_r     <= s1_vld_nxt;
      fwd_sel_r    <= fwd_sel_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r <= in_data.cmd;
      s1_idx_r <= idx_in;
      s1_tag_r <= tag_in;
    end
    fwd_data_r <= upd_entry;
    if (s1_vld_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
